// ===== src/ipb_pkg.sv =====
// Shared constants, codes and control structs of the inverse permutation builder.
package ipb_pkg;

    localparam int DEPTH_DEF = 1024;

    localparam int FUNC_W  = 2;
    localparam int IDX_W   = 32;
    localparam int POS_W   = 10;
    localparam int CNT_W   = 11;
    localparam int CFG_W   = 11;
    localparam int EPOCH_W = 8;

    // Item function codes; the fourth code does nothing.
    localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_TOP_INDEX  = 1'b0;
    localparam logic CFG_ELEM_COUNT = 1'b1;

    typedef struct packed {
        logic start;      // start transaction accepted
        logic load;       // load transaction accepted
        logic rd_issue;   // read transaction accepted, memory read issued
        logic item_done;  // non-read transaction accepted, result loads now
        logic rd_done;    // memory data ready, read result loads now
        logic clear;      // clearing sweep active
    } t_cmd;

    typedef struct packed {
        logic epoch_last; // next start wraps the epoch
        logic sweep_last; // sweep is at the last entry
    } t_status;

endpackage

// ===== src/ipb_ctrl.sv =====
// Controller: handshakes, command decode and clearing-sweep sequencing.
module ipb_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [ipb_pkg::FUNC_W-1:0]      i_func,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    input  ipb_pkg::t_status                i_status,
    output ipb_pkg::t_cmd                   o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_RUN   = 3'b010,
        S_READ  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   can_take;
    logic   in_accept;
    logic   out_take;

    assign out_take  = r_out_valid && !i_out_stall;
    assign can_take  = (r_state == S_RUN) && (!r_out_valid || !i_out_stall);
    assign in_accept = i_in_valid && can_take;

    assign o_in_stall  = !can_take;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd           = '0;
        o_cmd.start     = in_accept && (i_func == ipb_pkg::FUNC_START);
        o_cmd.load      = in_accept && (i_func == ipb_pkg::FUNC_LOAD);
        o_cmd.rd_issue  = in_accept && (i_func == ipb_pkg::FUNC_READ);
        o_cmd.item_done = in_accept && (i_func != ipb_pkg::FUNC_READ);
        o_cmd.rd_done   = (r_state == S_READ);
        o_cmd.clear     = (r_state == S_CLEAR);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_status.sweep_last) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (o_cmd.rd_issue) begin
                    n_state = S_READ;
                end else if (o_cmd.start && i_status.epoch_last) begin
                    n_state = S_CLEAR;
                end
            end
            S_READ: begin
                n_state = S_RUN;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.item_done || o_cmd.rd_done) begin
            n_out_valid = 1'b1;
        end else if (out_take) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_read_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !r_out_valid)
        else $error("read result would overwrite a pending result");

    a_read_goes_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_issue |=> ((r_state == S_READ) && !r_out_valid) ##1 r_out_valid)
        else $error("read transaction did not produce its result");

    a_no_take_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !in_accept)
        else $error("transaction accepted during clearing sweep");

endmodule

// ===== src/ipb_dp.sv =====
// Datapath: configuration, position table, counter, error flag and result register.
module ipb_dp #(
    parameter int DEPTH = ipb_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ipb_pkg::t_cmd                     i_cmd,
    output ipb_pkg::t_status                  o_status,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [ipb_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic signed [ipb_pkg::IDX_W-1:0]  i_index_value,
    input  logic                              i_index_is_null,
    input  logic [ipb_pkg::POS_W-1:0]         i_read_position,
    output logic [ipb_pkg::POS_W-1:0]         o_position_value,
    output logic                              o_entry_valid,
    output logic                              o_read_in_range,
    output logic                              o_error_flag
);

    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WORD_W = ipb_pkg::EPOCH_W + ipb_pkg::POS_W;
    localparam logic [16:0]   DEPTH_W  = 17'(DEPTH);
    localparam logic [AW-1:0] LAST_ADR = AW'(DEPTH - 1);

    logic [ipb_pkg::CFG_W-1:0]    r_top_index;
    logic [ipb_pkg::CFG_W-1:0]    r_elem_count;
    logic [ipb_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic                         r_err, n_err;
    logic [ipb_pkg::EPOCH_W-1:0]  r_epoch, n_epoch;
    logic [AW-1:0]                r_sweep;
    logic [WORD_W-1:0]            r_mem [DEPTH];
    logic [WORD_W-1:0]            r_rd_word;
    logic                         r_rd_in_range;
    logic [ipb_pkg::POS_W-1:0]    r_out_pos;
    logic                         r_out_ev;
    logic                         r_out_ir;
    logic                         r_out_err;

    logic [ipb_pkg::CNT_W-1:0]    len_raw;
    logic [ipb_pkg::CNT_W-1:0]    len;
    logic                         idx_oob;
    logic                         load_we;
    logic                         mem_we;
    logic [AW-1:0]                mem_wadr;
    logic [WORD_W-1:0]            mem_wdata;
    logic [AW-1:0]                rpos_ext;
    logic                         rpos_in_range;
    logic                         epoch_match;

    // Output length: top index plus one, or element_count when the top index
    // is negative, saturated at DEPTH.
    always_comb begin
        if (r_top_index[ipb_pkg::CFG_W-1]) begin
            len_raw = r_elem_count;
        end else begin
            len_raw = {1'b0, r_top_index[ipb_pkg::CFG_W-2:0]} + ipb_pkg::CNT_W'(1);
        end
        if (17'(len_raw) > DEPTH_W) begin
            len = DEPTH_W[ipb_pkg::CNT_W-1:0];
        end else begin
            len = len_raw;
        end
    end

    assign idx_oob = i_index_value[ipb_pkg::IDX_W-1]
                  || (i_index_value[ipb_pkg::IDX_W-2:0] >= 31'(len));

    assign rpos_ext      = AW'(i_read_position);
    assign rpos_in_range = ({1'b0, i_read_position} < len);

    assign o_status.epoch_last = &r_epoch;
    assign o_status.sweep_last = (r_sweep == LAST_ADR);

    always_comb begin
        n_cnt   = r_cnt;
        n_err   = r_err;
        n_epoch = r_epoch;
        load_we = 1'b0;
        if (i_cmd.start) begin
            n_cnt   = '0;
            n_err   = 1'b0;
            n_epoch = o_status.epoch_last ? ipb_pkg::EPOCH_W'(1)
                                          : r_epoch + ipb_pkg::EPOCH_W'(1);
        end else if (i_cmd.load && !r_err) begin
            if (i_index_is_null) begin
                n_cnt = r_cnt + ipb_pkg::CNT_W'(1);
            end else if (idx_oob) begin
                n_err = 1'b1;
            end else begin
                load_we = 1'b1;
                n_cnt   = r_cnt + ipb_pkg::CNT_W'(1);
            end
        end
    end

    // Sweep writes epoch zero, which no run ever uses.
    always_comb begin
        if (i_cmd.clear) begin
            mem_we    = 1'b1;
            mem_wadr  = r_sweep;
            mem_wdata = '0;
        end else begin
            mem_we    = load_we;
            mem_wadr  = i_index_value[AW-1:0];
            mem_wdata = {r_epoch, r_cnt[ipb_pkg::POS_W-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wadr] <= mem_wdata;
        end
        if (i_cmd.rd_issue) begin
            r_rd_word     <= r_mem[rpos_ext];
            r_rd_in_range <= rpos_in_range;
        end
    end

    assign epoch_match = (r_rd_word[WORD_W-1:ipb_pkg::POS_W] == r_epoch);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_index  <= '1;
            r_elem_count <= '0;
            r_cnt        <= '0;
            r_err        <= 1'b0;
            r_epoch      <= ipb_pkg::EPOCH_W'(1);
            r_sweep      <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == ipb_pkg::CFG_TOP_INDEX) begin
                    r_top_index <= i_cfg_data;
                end else begin
                    r_elem_count <= i_cfg_data;
                end
            end
            r_cnt   <= n_cnt;
            r_err   <= n_err;
            r_epoch <= n_epoch;
            if (i_cmd.clear) begin
                r_sweep <= o_status.sweep_last ? '0 : r_sweep + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.item_done) begin
            r_out_pos <= '0;
            r_out_ev  <= 1'b0;
            r_out_ir  <= 1'b0;
            r_out_err <= n_err;
        end else if (i_cmd.rd_done) begin
            r_out_pos <= (r_rd_in_range && epoch_match) ?
                         r_rd_word[ipb_pkg::POS_W-1:0] : '0;
            r_out_ev  <= r_rd_in_range && epoch_match;
            r_out_ir  <= r_rd_in_range;
            r_out_err <= r_err;
        end
    end

    assign o_position_value = r_out_pos;
    assign o_entry_valid    = r_out_ev;
    assign o_read_in_range  = r_out_ir;
    assign o_error_flag     = r_out_err;

    a_epoch_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_epoch != '0)
        else $error("run epoch collides with the cleared mark");

    a_write_in_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_we |-> !i_index_value[ipb_pkg::IDX_W-1]
                    && (i_index_value[ipb_pkg::IDX_W-2:0] < 31'(len)))
        else $error("table write outside the output length");

    a_err_blocks_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err && !i_cmd.start) |=> r_err && $stable(r_cnt))
        else $error("load changed state after an error");

endmodule

// ===== src/inverse_permutation_builder_top.sv =====
// Top level of the inverse permutation builder: controller plus datapath.
//
// Builds the inverse of an index sequence. A start transaction clears the
// valid marks, position counter and sticky error; each load transaction
// stores the current position at the given index (a null only advances the
// position, an index out of range sets the sticky error and blocks further
// loads until the next start); a read transaction returns one table entry,
// its valid mark and an in-range flag. Every transaction yields one result.
// Start, load and the unused function code load their result in the next
// cycle; a read passes the position table's registered read port and then
// the result register. Valid marks are an 8-bit run epoch stored next to
// each position, so a start clears the table without writing it. After reset,
// and after every 255th start, the block sweeps all DEPTH entries clear, one
// table entry per cycle, stalling input meanwhile; configuration writes are
// taken at any time. A finished result sits in an output register, so the
// next transaction is taken while the result waits, as long as the output
// side takes it in the same cycle or the register is empty.
module inverse_permutation_builder_top #(
    parameter int DEPTH = ipb_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input transaction channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [ipb_pkg::FUNC_W-1:0]        i_func,
    input  logic signed [ipb_pkg::IDX_W-1:0]  i_index_value,
    input  logic                              i_index_is_null,
    input  logic [ipb_pkg::POS_W-1:0]         i_read_position,
    // result transaction channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [ipb_pkg::POS_W-1:0]         o_position_value,
    output logic                              o_entry_valid,
    output logic                              o_read_in_range,
    output logic                              o_error_flag,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic                              i_cfg_index,
    input  logic [ipb_pkg::CFG_W-1:0]         i_cfg_data
);

    ipb_pkg::t_cmd    cmd;
    ipb_pkg::t_status status;

    // Registers are plain flops; a write always completes.
    assign o_cfg_ready = 1'b1;

    ipb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_func      (i_func),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    ipb_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_index_value    (i_index_value),
        .i_index_is_null  (i_index_is_null),
        .i_read_position  (i_read_position),
        .o_position_value (o_position_value),
        .o_entry_valid    (o_entry_valid),
        .o_read_in_range  (o_read_in_range),
        .o_error_flag     (o_error_flag)
    );

endmodule
